// ===== rtl/turtle_grid_plotter_core_macros.svh =====
// ----------------------------------------------------------------------------
// turtle_grid_plotter_core_macros
// Assertion helpers shared by the plotter RTL. All use clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef TURTLE_GRID_PLOTTER_CORE_MACROS_SVH
`define TURTLE_GRID_PLOTTER_CORE_MACROS_SVH

// same-cycle implication
`define TGP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define TGP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== rtl/tgp_pkg.sv =====
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared widths, opcodes, register indexes and cell codes of the plotter.
// ----------------------------------------------------------------------------
package tgp_pkg;

	localparam int GRID_SIZE_DEF = 20;

	localparam int OPCODE_W    = 3;
	localparam int DIST_W      = 5;
	localparam int ROW_NUM_W   = 5;
	localparam int CELL_W      = 2;
	localparam int ROW_CELLS_N = 20;
	localparam int ROW_CELLS_W = ROW_CELLS_N * CELL_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int SUM_W       = 6;
	localparam int HEAD_W      = 2;

	localparam logic [OPCODE_W-1:0] OP_PEN_UP    = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PEN_DOWN  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TURN_R    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_TURN_L    = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_MOVE      = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_SHOW      = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_HALT      = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_START_ROW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_COL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd2;

	localparam logic [HEAD_W-1:0] HEAD_N = 2'd0;
	localparam logic [HEAD_W-1:0] HEAD_E = 2'd1;
	localparam logic [HEAD_W-1:0] HEAD_S = 2'd2;
	localparam logic [HEAD_W-1:0] HEAD_W_ = 2'd3;

	localparam logic [CELL_W-1:0] CELL_BLANK = 2'd0;
	localparam logic [CELL_W-1:0] CELL_DRAWN = 2'd1;
	localparam logic [CELL_W-1:0] CELL_DOT   = 2'd2;

	localparam int START_ROW_RST  = 5;
	localparam int START_COL_RST  = 5;
	localparam logic [HEAD_W-1:0] START_HEAD_RST = HEAD_E;

endpackage

// ===== rtl/turtle_grid_plotter_core.sv =====
// ----------------------------------------------------------------------------
// turtle_grid_plotter_core
// Turtle plotter on a GRID_SIZE x GRID_SIZE bit grid held in a row RAM.
//
// Items enter on in_valid/in_stall (opcode, distance); one item is taken at
// a time, in_stall is high while an item is at work. Shows leave on
// out_valid/out_stall, one item per grid row, last_row on the final one.
// Start row, column and heading are written on cfg_valid/cfg_ready; a write
// also places the turtle at once.
// Pen up, turns, halt and pen-up moves need no RAM access; pen down and
// horizontal pen-down moves do a read-modify-write of one row; vertical
// pen-down moves and shows stream rows through the single RAM read port,
// one row a cycle, for a show only while the output row is not stalled.
// A stalled output row is held in the output register and the row reads
// pause behind it; the next item may enter while the last row still waits.
// Reset clears the grid through per-row valid bits at once, no sweep.
// After a halt, items are taken and dropped until reset.
// ----------------------------------------------------------------------------
`include "turtle_grid_plotter_core_macros.svh"

module turtle_grid_plotter_core #(
	parameter int GRID_SIZE = tgp_pkg::GRID_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tgp_pkg::OPCODE_W-1:0]     opcode,
	input  logic [tgp_pkg::DIST_W-1:0]       distance,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tgp_pkg::ROW_NUM_W-1:0]    row_number,
	output logic [tgp_pkg::ROW_CELLS_W-1:0]  row_cells,
	output logic                             last_row,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tgp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tgp_pkg::*;

	localparam int POS_W = $clog2(GRID_SIZE);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(GRID_SIZE - 1);
	localparam logic [SUM_W-1:0] LAST_SUM = SUM_W'(GRID_SIZE - 1);
	localparam logic [POS_W-1:0] POS_ROW_RST =
		POS_W'((START_ROW_RST > GRID_SIZE - 1) ? GRID_SIZE - 1 : START_ROW_RST);
	localparam logic [POS_W-1:0] POS_COL_RST =
		POS_W'((START_COL_RST > GRID_SIZE - 1) ? GRID_SIZE - 1 : START_COL_RST);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_MARK_RD = 3'd1;
	localparam logic [2:0] ST_MARK_WR = 3'd2;
	localparam logic [2:0] ST_VMOVE   = 3'd3;
	localparam logic [2:0] ST_SHOW    = 3'd4;

	logic [2:0]           state_q;
	logic [POS_W-1:0]     pos_row_q;
	logic [POS_W-1:0]     pos_col_q;
	logic [HEAD_W-1:0]    heading_q;
	logic                 pen_q;
	logic                 halted_q;
	logic [GRID_SIZE-1:0] row_valid_q;

	logic [POS_W-1:0]     ptr_q;
	logic [POS_W-1:0]     end_q;
	logic                 issue_done_q;
	logic [POS_W-1:0]     mark_row_q;
	logic [GRID_SIZE-1:0] mark_mask_q;

	logic                 pending_s1;
	logic [POS_W-1:0]     row_s1;

	logic                    out_valid_q;
	logic [ROW_NUM_W-1:0]    row_number_q;
	logic [ROW_CELLS_W-1:0]  row_cells_q;
	logic                    last_row_q;

	logic                 ram_wr_en;
	logic [POS_W-1:0]     ram_wr_addr;
	logic [GRID_SIZE-1:0] ram_wr_data;
	logic                 ram_rd_en;
	logic [POS_W-1:0]     ram_rd_addr;
	logic [GRID_SIZE-1:0] ram_rd_data;

	logic                 in_acc;
	logic                 cfg_acc;
	logic                 stream;
	logic                 out_load;
	logic                 consume;
	logic [GRID_SIZE-1:0] row_clean;
	logic [ROW_CELLS_N-1:0] row_pad;
	logic [ROW_CELLS_W-1:0] cells;
	logic                 row_border;

	logic                 vertical;
	logic [POS_W-1:0]     cur;
	logic [SUM_W-1:0]     cur_ext;
	logic [SUM_W-1:0]     dist_ext;
	logic [SUM_W-1:0]     sum;
	logic [POS_W-1:0]     target;
	logic [POS_W-1:0]     lo;
	logic [POS_W-1:0]     hi;
	logic [GRID_SIZE-1:0] range_mask;
	logic [GRID_SIZE-1:0] col_mask;
	logic [POS_W-1:0]     cfg_pos;

	tgp_ram #(
		.WIDTH (GRID_SIZE),
		.DEPTH (GRID_SIZE)
	) u_grid (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;

	// move target, saturated at the grid edge
	always_comb begin
		vertical = (heading_q == HEAD_N) || (heading_q == HEAD_S);
		cur      = vertical ? pos_row_q : pos_col_q;
		cur_ext  = SUM_W'(cur);
		dist_ext = SUM_W'(distance);
		sum      = cur_ext + dist_ext;
		if ((heading_q == HEAD_N) || (heading_q == HEAD_W_)) begin
			target = (dist_ext > cur_ext) ? '0 : POS_W'(cur_ext - dist_ext);
		end else begin
			target = (sum > LAST_SUM) ? LAST_POS : POS_W'(sum);
		end
		lo = (target < cur) ? target : cur;
		hi = (target < cur) ? cur : target;
		for (int c = 0; c < GRID_SIZE; c++) begin
			range_mask[c] = (POS_W'(c) >= lo) && (POS_W'(c) <= hi);
		end
		col_mask = {{(GRID_SIZE-1){1'b0}}, 1'b1} << pos_col_q;
		cfg_pos  = (SUM_W'(cfg_data) > LAST_SUM) ? LAST_POS : POS_W'(cfg_data);
	end

	// row read pipeline shared by marking, vertical moves and shows
	assign stream    = (state_q == ST_VMOVE) || (state_q == ST_SHOW);
	assign ram_wr_en = pending_s1 && ((state_q == ST_VMOVE) || (state_q == ST_MARK_WR));
	assign out_load  = pending_s1 && (state_q == ST_SHOW) && (!out_valid_q || !out_stall);
	assign consume   = ram_wr_en || out_load;
	assign ram_rd_en = (state_q == ST_MARK_RD) ||
		(stream && !issue_done_q && (!pending_s1 || consume));
	assign ram_rd_addr = (state_q == ST_MARK_RD) ? mark_row_q : ptr_q;

	// rows never written since reset read as cleared
	assign row_clean   = row_valid_q[row_s1] ? ram_rd_data : '0;
	assign ram_wr_addr = row_s1;
	assign ram_wr_data = row_clean | mark_mask_q;

	always_comb begin
		row_pad    = ROW_CELLS_N'(row_clean);
		row_border = (row_s1 == '0) || (row_s1 == LAST_POS);
		for (int c = 0; c < ROW_CELLS_N; c++) begin
			if (c >= GRID_SIZE) begin
				cells[c*CELL_W +: CELL_W] = CELL_BLANK;
			end else if (row_pad[c]) begin
				cells[c*CELL_W +: CELL_W] = CELL_DRAWN;
			end else if (row_border || (c == 0) || (c == GRID_SIZE - 1)) begin
				cells[c*CELL_W +: CELL_W] = CELL_DOT;
			end else begin
				cells[c*CELL_W +: CELL_W] = CELL_BLANK;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_row_q    <= POS_ROW_RST;
			pos_col_q    <= POS_COL_RST;
			heading_q    <= START_HEAD_RST;
			pen_q        <= 1'b0;
			halted_q     <= 1'b0;
			row_valid_q  <= '0;
			issue_done_q <= 1'b0;
			pending_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ram_rd_en) begin
				pending_s1 <= 1'b1;
			end else if (consume) begin
				pending_s1 <= 1'b0;
			end

			if (ram_wr_en) begin
				row_valid_q[ram_wr_addr] <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (stream && ram_rd_en && (ptr_q == end_q)) begin
				issue_done_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && !halted_q) begin
						case (opcode)
							OP_PEN_UP: begin
								pen_q <= 1'b0;
							end
							OP_PEN_DOWN: begin
								pen_q   <= 1'b1;
								state_q <= ST_MARK_RD;
							end
							OP_TURN_R: begin
								heading_q <= heading_q + HEAD_W'(1);
							end
							OP_TURN_L: begin
								heading_q <= heading_q - HEAD_W'(1);
							end
							OP_MOVE: begin
								if (vertical) begin
									pos_row_q <= target;
								end else begin
									pos_col_q <= target;
								end
								if (pen_q) begin
									state_q      <= vertical ? ST_VMOVE : ST_MARK_RD;
									issue_done_q <= 1'b0;
								end
							end
							OP_SHOW: begin
								state_q      <= ST_SHOW;
								issue_done_q <= 1'b0;
							end
							OP_HALT: begin
								halted_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
					if (cfg_acc) begin
						case (cfg_index)
							CFG_START_ROW:  pos_row_q <= cfg_pos;
							CFG_START_COL:  pos_col_q <= cfg_pos;
							CFG_START_HEAD: heading_q <= HEAD_W'(cfg_data);
							default: begin
							end
						endcase
					end
				end
				ST_MARK_RD: begin
					state_q <= ST_MARK_WR;
				end
				ST_MARK_WR: begin
					state_q <= ST_IDLE;
				end
				ST_VMOVE: begin
					if (pending_s1 && issue_done_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SHOW: begin
					if (out_load && issue_done_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ram_rd_en) begin
			row_s1 <= ram_rd_addr;
		end
		if (stream && ram_rd_en) begin
			ptr_q <= ptr_q + POS_W'(1);
		end
		if (in_acc && (state_q == ST_IDLE)) begin
			mark_row_q <= pos_row_q;
			case (opcode)
				OP_PEN_DOWN: begin
					mark_mask_q <= col_mask;
				end
				OP_MOVE: begin
					mark_mask_q <= vertical ? col_mask : range_mask;
					ptr_q       <= lo;
					end_q       <= hi;
				end
				OP_SHOW: begin
					ptr_q <= '0;
					end_q <= LAST_POS;
				end
				default: begin
				end
			endcase
		end
		if (out_load) begin
			row_number_q <= ROW_NUM_W'(row_s1);
			row_cells_q  <= cells;
			last_row_q   <= (row_s1 == LAST_POS);
		end
	end

	assign out_valid  = out_valid_q;
	assign row_number = row_number_q;
	assign row_cells  = row_cells_q;
	assign last_row   = last_row_q;

	`TGP_ASSERT_IMP(a_no_rw_clash, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
	`TGP_ASSERT_IMP(a_out_hold, out_valid_q && out_stall, !out_load)
	`TGP_ASSERT_IMP(a_halt_idle, halted_q, state_q == ST_IDLE)
	`TGP_ASSERT_NXT(a_mark_seq, state_q == ST_MARK_RD, (state_q == ST_MARK_WR) && pending_s1)
	`TGP_ASSERT_IMP(a_last_row, out_valid_q, last_row_q == (row_number_q == ROW_NUM_W'(GRID_SIZE - 1)))

endmodule

// ===== rtl/tgp_ram.sv =====
// ----------------------------------------------------------------------------
// tgp_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// that holds while no read is enabled.
// ----------------------------------------------------------------------------
module tgp_ram #(
	parameter int WIDTH = tgp_pkg::GRID_SIZE_DEF,
	parameter int DEPTH = tgp_pkg::GRID_SIZE_DEF,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
